// ===== hw/rtl/assert_macros.svh =====
// assertion macros shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked property, quiet while reset is asserted
`define SDFM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked property, also live during reset
`define SDFM_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/sdfm_pkg.sv =====
// shared types and constants of the shape distance merge block
package sdfm_pkg;

	localparam int FRAC_BITS = 14;
	localparam int ROT_BITS  = 14;

	localparam int POS_W  = 17;
	localparam int SIZE_W = 14;
	localparam int ROT_W  = 16;
	localparam int DIST_W = 18;
	localparam int KIND_W = 3;

	localparam int MW    = 22;
	localparam int WW    = 44;
	localparam int SIG_W = 21;
	localparam int DIVW  = 34;
	localparam int LEN_W = 16;

	localparam int SQ_STEPS = WW / 2;
	localparam int DV_STEPS = DIVW;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = 1;
	localparam int QCNT_W = 2;

	localparam longint ONE         = longint'(1) << FRAC_BITS;
	localparam longint K_SQRT3_2   = (longint'(866025) * ONE + 500000) / 1000000;
	localparam longint CORNER_RAD  = (5 * ONE + 50) / 100;
	localparam longint LINE_HALF_W = (25 * ONE + 500) / 1000;

	localparam logic [KIND_W-1:0] KIND_LINE   = 3'd0;
	localparam logic [KIND_W-1:0] KIND_BOX    = 3'd1;
	localparam logic [KIND_W-1:0] KIND_TRI    = 3'd2;
	localparam logic [KIND_W-1:0] KIND_CIRCLE = 3'd3;
	localparam logic [KIND_W-1:0] KIND_NONE   = 3'd4;

	localparam logic REG_EXTENT_W = 1'b0;
	localparam logic REG_EXTENT_H = 1'b1;

	localparam logic [POS_W-1:0] EXTENT_RESET = POS_W'(ONE);

	typedef logic signed [WW-1:0]    wide_t;
	typedef logic signed [MW-1:0]    mop_t;
	typedef logic signed [SIG_W-1:0] sig_t;

	typedef struct packed {
		logic [KIND_W-1:0]        kind;
		logic signed [POS_W:0]    dx;
		logic signed [POS_W:0]    dy;
		logic signed [POS_W+1:0]  fqx;
		logic signed [POS_W+1:0]  fqy;
		logic [SIZE_W-1:0]        sz;
		logic signed [ROT_W-1:0]  cs;
		logic signed [ROT_W-1:0]  sn;
		logic                     first;
		logic                     last;
	} item_t;

endpackage

// ===== hw/rtl/sdfm_front.sv =====
// front end: frame registers, beat acceptance and item classification
module sdfm_front
	import sdfm_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic                    cfg_index,
	input  logic [POS_W-1:0]        cfg_data,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [POS_W-1:0]        pixel_x,
	input  logic [POS_W-1:0]        pixel_y,
	input  logic [KIND_W-1:0]       shape_kind,
	input  logic [POS_W-1:0]        center_x,
	input  logic [POS_W-1:0]        center_y,
	input  logic [SIZE_W-1:0]       shape_size,
	input  logic signed [ROT_W-1:0] rot_cos,
	input  logic signed [ROT_W-1:0] rot_sin,
	input  logic                    first_shape,
	input  logic                    last_shape,
	input  logic                    q_full,
	output logic                    q_push,
	output item_t                   q_item
);

	logic [POS_W-1:0] extent_w_q, extent_h_q;
	logic [POS_W-2:0] hw, hh;
	logic signed [POS_W+1:0] ox, oy, ax, ay;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			extent_w_q <= EXTENT_RESET;
			extent_h_q <= EXTENT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_EXTENT_W: extent_w_q <= cfg_data;
				REG_EXTENT_H: extent_h_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// frame offsets from the box centre
	assign hw = extent_w_q[POS_W-1:1];
	assign hh = extent_h_q[POS_W-1:1];
	assign ox = $signed({2'b00, pixel_x}) - $signed({3'b000, hw});
	assign oy = $signed({2'b00, pixel_y}) - $signed({3'b000, hh});
	assign ax = (ox < 0) ? -ox : ox;
	assign ay = (oy < 0) ? -oy : oy;

	always_comb begin
		q_item.dx    = $signed({1'b0, pixel_x}) - $signed({1'b0, center_x});
		q_item.dy    = $signed({1'b0, pixel_y}) - $signed({1'b0, center_y});
		q_item.fqx   = ax - $signed({3'b000, hw});
		q_item.fqy   = ay - $signed({3'b000, hh});
		q_item.sz    = shape_size;
		q_item.cs    = rot_cos;
		q_item.sn    = rot_sin;
		q_item.first = first_shape;
		q_item.last  = last_shape;
		case (shape_kind)
			KIND_LINE:   q_item.kind = KIND_LINE;
			KIND_BOX:    q_item.kind = KIND_BOX;
			KIND_TRI:    q_item.kind = KIND_TRI;
			KIND_CIRCLE: q_item.kind = KIND_CIRCLE;
			default:     q_item.kind = KIND_NONE;
		endcase
	end

	assign in_stall = q_full;
	assign q_push   = in_valid && !q_full;

endmodule

// ===== hw/rtl/sdfm_queue.sv =====
// short item queue between front end and back end
module sdfm_queue
	import sdfm_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  full,
	input  logic  pop,
	output item_t pop_item,
	output logic  nempty
);

	item_t             slot_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full     = (cnt_q == QCNT_W'(QDEPTH));
	assign nempty   = (cnt_q != '0);
	assign pop_item = slot_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop)  rd_q <= rd_q + 1'b1;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_q] <= push_item;
	end

endmodule

// ===== hw/rtl/sdfm_back.sv =====
// back end: distance sequencer with shared multiplier, root and divider
module sdfm_back
	import sdfm_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     q_nempty,
	input  item_t                    q_item,
	output logic                     q_pop,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [DIST_W-1:0] distance
);

	localparam logic [4:0] ST_IDLE   = 5'd0;
	localparam logic [4:0] ST_FRAME  = 5'd1;
	localparam logic [4:0] ST_FDONE  = 5'd2;
	localparam logic [4:0] ST_SHAPE  = 5'd3;
	localparam logic [4:0] ST_V1     = 5'd4;
	localparam logic [4:0] ST_V2     = 5'd5;
	localparam logic [4:0] ST_SQRT   = 5'd6;
	localparam logic [4:0] ST_DSTART = 5'd7;
	localparam logic [4:0] ST_DIV    = 5'd8;
	localparam logic [4:0] ST_CDONE  = 5'd9;
	localparam logic [4:0] ST_R1     = 5'd10;
	localparam logic [4:0] ST_R2     = 5'd11;
	localparam logic [4:0] ST_R3     = 5'd12;
	localparam logic [4:0] ST_R4     = 5'd13;
	localparam logic [4:0] ST_B1     = 5'd14;
	localparam logic [4:0] ST_BDONE  = 5'd15;
	localparam logic [4:0] ST_T1     = 5'd16;
	localparam logic [4:0] ST_T2     = 5'd17;
	localparam logic [4:0] ST_L1     = 5'd18;
	localparam logic [4:0] ST_L2     = 5'd19;
	localparam logic [4:0] ST_L3     = 5'd20;
	localparam logic [4:0] ST_L4     = 5'd21;
	localparam logic [4:0] ST_L5     = 5'd22;
	localparam logic [4:0] ST_L6     = 5'd23;
	localparam logic [4:0] ST_L7     = 5'd24;
	localparam logic [4:0] ST_L8     = 5'd25;
	localparam logic [4:0] ST_L9     = 5'd26;
	localparam logic [4:0] ST_LDONE  = 5'd27;
	localparam logic [4:0] ST_MERGE  = 5'd28;

	localparam wide_t ROT_HALF  = wide_t'(longint'(1) << (ROT_BITS - 1));
	localparam wide_t LINE_HALF = wide_t'(longint'(1) << ROT_BITS);
	localparam wide_t FRAC_HALF = wide_t'(longint'(1) << (FRAC_BITS - 1));
	localparam wide_t OUT_MAX   = wide_t'((longint'(1) << (DIST_W - 1)) - 1);
	localparam wide_t OUT_MIN   = wide_t'(-(longint'(1) << (DIST_W - 1)));
	localparam logic [WW-1:0] SQ_TOP = WW'(1) << (WW - 2);

	logic [4:0]  state_q, ret_q;
	logic [5:0]  cnt_q;
	item_t       it_q;
	wide_t       acc_q, e_q, p_q, sq_q;
	logic        has_q;
	sig_t        rx_q, ry_q, sx_q, sy_q, vx_q, vy_q;
	logic signed [ROT_W-1:0] hvx_q;
	logic signed [ROT_W:0]   dirx_q, diry_q;
	logic [LEN_W-1:0] len_q, t_q;
	logic [WW-1:0]    sn_q, sr_q, sb_q;
	logic [DIVW-1:0]  dq_q;
	logic [LEN_W-1:0] rem_q;
	logic             dneg_q;
	logic signed [DIST_W-1:0] running_min_q, dist_q;
	logic             out_valid_q;

	mop_t  mul_a, mul_b;
	wide_t mul_p;
	sig_t  abs_rx, bqx, bqy, half_sz;
	logic signed [ROT_W-1:0] hvy_c;
	logic [WW-1:0]   sq_sum;
	logic            sq_ge;
	logic [LEN_W:0]  dv_r2;
	logic            dv_ge;
	logic signed [DIVW:0] quot;
	wide_t tri_a, merge_v, merge_sat, fmin, bmin;

	// shared multiplier operands
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_V1:  begin mul_a = mop_t'(vx_q); mul_b = mop_t'(vx_q); end
			ST_V2:  begin mul_a = mop_t'(vy_q); mul_b = mop_t'(vy_q); end
			ST_R1:  begin mul_a = mop_t'(it_q.dx); mul_b = mop_t'(it_q.cs); end
			ST_R2:  begin mul_a = mop_t'(it_q.dy); mul_b = mop_t'(it_q.sn); end
			ST_R3:  begin mul_a = mop_t'(it_q.dx); mul_b = mop_t'(it_q.sn); end
			ST_R4:  begin mul_a = mop_t'(it_q.dy); mul_b = mop_t'(it_q.cs); end
			ST_T1:  begin mul_a = mop_t'(abs_rx); mul_b = mop_t'(K_SQRT3_2); end
			ST_L1:  begin mul_a = mop_t'(it_q.sz); mul_b = mop_t'(it_q.cs); end
			ST_L2:  begin mul_a = mop_t'(it_q.sz); mul_b = mop_t'(it_q.sn); end
			ST_L4:  begin mul_a = mop_t'(sx_q); mul_b = mop_t'(dirx_q); end
			ST_L5:  begin mul_a = mop_t'(sy_q); mul_b = mop_t'(diry_q); end
			ST_L7:  begin mul_a = mop_t'(t_q); mul_b = mop_t'(dirx_q); end
			ST_L8:  begin mul_a = mop_t'(t_q); mul_b = mop_t'(diry_q); end
			default: ;
		endcase
	end

	// full-width product of the two signed operands
	assign mul_p = wide_t'(mul_a) * wide_t'(mul_b);

	assign abs_rx  = (rx_q < 0) ? -rx_q : rx_q;
	assign half_sz = sig_t'(it_q.sz >> 1);
	assign bqx     = abs_rx - (half_sz - sig_t'(CORNER_RAD));
	assign bqy     = ((ry_q < 0) ? -ry_q : ry_q) - (half_sz - sig_t'(CORNER_RAD));
	assign bmin    = (bqx > bqy) ? ((bqx < 0) ? wide_t'(bqx) : '0)
	                             : ((bqy < 0) ? wide_t'(bqy) : '0);
	assign fmin    = (it_q.fqx > it_q.fqy) ? ((it_q.fqx < 0) ? wide_t'(it_q.fqx) : '0)
	                                       : ((it_q.fqy < 0) ? wide_t'(it_q.fqy) : '0);
	assign hvy_c   = ROT_W'((p_q + LINE_HALF) >>> (ROT_BITS + 1));

	// one root bit per cycle
	assign sq_sum = sr_q + sb_q;
	assign sq_ge  = (sn_q >= sq_sum);

	// one quotient bit per cycle
	assign dv_r2 = {rem_q, dq_q[DIVW-1]};
	assign dv_ge = (dv_r2 >= {1'b0, len_q});
	assign quot  = dneg_q ? -$signed({1'b0, dq_q}) : $signed({1'b0, dq_q});

	assign tri_a = (p_q + (wide_t'(ry_q) <<< (FRAC_BITS - 1)) + FRAC_HALF) >>> FRAC_BITS;

	assign merge_v   = (has_q && (e_q < acc_q)) ? e_q : acc_q;
	assign merge_sat = (merge_v > OUT_MAX) ? OUT_MAX :
	                   (merge_v < OUT_MIN) ? OUT_MIN : merge_v;

	assign q_pop     = (state_q == ST_IDLE) && q_nempty;
	assign out_valid = out_valid_q;
	assign distance  = dist_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			ret_q         <= ST_IDLE;
			cnt_q         <= '0;
			it_q          <= '0;
			acc_q         <= '0;
			e_q           <= '0;
			p_q           <= '0;
			sq_q          <= '0;
			has_q         <= 1'b0;
			rx_q          <= '0;
			ry_q          <= '0;
			sx_q          <= '0;
			sy_q          <= '0;
			vx_q          <= '0;
			vy_q          <= '0;
			hvx_q         <= '0;
			dirx_q        <= '0;
			diry_q        <= '0;
			len_q         <= '0;
			t_q           <= '0;
			sn_q          <= '0;
			sr_q          <= '0;
			sb_q          <= '0;
			dq_q          <= '0;
			rem_q         <= '0;
			dneg_q        <= 1'b0;
			running_min_q <= '0;
			dist_q        <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (q_nempty) begin
						it_q  <= q_item;
						acc_q <= wide_t'(running_min_q);
						state_q <= q_item.first ? ST_FRAME : ST_SHAPE;
					end
				end
				ST_FRAME: begin
					vx_q    <= (it_q.fqx < 0) ? '0 : sig_t'(it_q.fqx);
					vy_q    <= (it_q.fqy < 0) ? '0 : sig_t'(it_q.fqy);
					ret_q   <= ST_FDONE;
					state_q <= ST_V1;
				end
				ST_FDONE: begin
					acc_q   <= -(fmin + wide_t'(sr_q));
					state_q <= ST_SHAPE;
				end
				ST_SHAPE: begin
					case (it_q.kind)
						KIND_CIRCLE: begin
							vx_q    <= sig_t'(it_q.dx);
							vy_q    <= sig_t'(it_q.dy);
							ret_q   <= ST_CDONE;
							state_q <= ST_V1;
						end
						KIND_LINE: state_q <= ST_L1;
						KIND_BOX:  state_q <= ST_R1;
						KIND_TRI:  state_q <= ST_R1;
						default: begin
							has_q   <= 1'b0;
							state_q <= ST_MERGE;
						end
					endcase
				end
				ST_V1: begin
					sq_q    <= mul_p;
					state_q <= ST_V2;
				end
				ST_V2: begin
					sn_q    <= WW'(sq_q + mul_p);
					sr_q    <= '0;
					sb_q    <= SQ_TOP;
					cnt_q   <= '0;
					state_q <= ST_SQRT;
				end
				ST_SQRT: begin
					if (sq_ge) begin
						sn_q <= sn_q - sq_sum;
						sr_q <= (sr_q >> 1) + sb_q;
					end else begin
						sr_q <= sr_q >> 1;
					end
					sb_q  <= sb_q >> 2;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 6'(SQ_STEPS - 1)) state_q <= ret_q;
				end
				ST_DSTART: begin
					dq_q    <= DIVW'((p_q < 0) ? -p_q : p_q);
					dneg_q  <= (p_q < 0);
					rem_q   <= '0;
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					rem_q <= dv_ge ? LEN_W'(dv_r2 - {1'b0, len_q}) : LEN_W'(dv_r2);
					dq_q  <= {dq_q[DIVW-2:0], dv_ge};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 6'(DV_STEPS - 1)) state_q <= ret_q;
				end
				ST_CDONE: begin
					e_q     <= wide_t'(sr_q) - wide_t'(it_q.sz);
					has_q   <= 1'b1;
					state_q <= ST_MERGE;
				end
				ST_R1: begin
					p_q     <= mul_p;
					state_q <= ST_R2;
				end
				ST_R2: begin
					rx_q    <= sig_t'((p_q - mul_p + ROT_HALF) >>> ROT_BITS);
					state_q <= ST_R3;
				end
				ST_R3: begin
					p_q     <= mul_p;
					state_q <= ST_R4;
				end
				ST_R4: begin
					ry_q    <= sig_t'((p_q + mul_p + ROT_HALF) >>> ROT_BITS);
					state_q <= (it_q.kind == KIND_BOX) ? ST_B1 : ST_T1;
				end
				ST_B1: begin
					vx_q    <= (bqx < 0) ? '0 : bqx;
					vy_q    <= (bqy < 0) ? '0 : bqy;
					e_q     <= bmin;
					ret_q   <= ST_BDONE;
					state_q <= ST_V1;
				end
				ST_BDONE: begin
					e_q     <= e_q + wide_t'(sr_q) - wide_t'(CORNER_RAD);
					has_q   <= 1'b1;
					state_q <= ST_MERGE;
				end
				ST_T1: begin
					p_q     <= mul_p;
					state_q <= ST_T2;
				end
				ST_T2: begin
					e_q     <= ((tri_a > -wide_t'(ry_q)) ? tri_a : -wide_t'(ry_q))
					           - wide_t'(half_sz);
					has_q   <= 1'b1;
					state_q <= ST_MERGE;
				end
				ST_L1: begin
					p_q     <= mul_p;
					state_q <= ST_L2;
				end
				ST_L2: begin
					hvx_q   <= ROT_W'((p_q + LINE_HALF) >>> (ROT_BITS + 1));
					p_q     <= mul_p;
					state_q <= ST_L3;
				end
				ST_L3: begin
					sx_q    <= sig_t'(-int'(it_q.dx) - int'(hvx_q));
					sy_q    <= sig_t'(-int'(it_q.dy) - int'(hvy_c));
					dirx_q  <= (ROT_W+1)'(-2 * int'(hvx_q));
					diry_q  <= (ROT_W+1)'(-2 * int'(hvy_c));
					vx_q    <= sig_t'(-2 * int'(hvx_q));
					vy_q    <= sig_t'(-2 * int'(hvy_c));
					ret_q   <= ST_L4;
					state_q <= ST_V1;
				end
				ST_L4: begin
					len_q <= LEN_W'(sr_q);
					if (sr_q == '0) begin
						// both ends coincide: distance to the point
						vx_q    <= sx_q;
						vy_q    <= sy_q;
						ret_q   <= ST_LDONE;
						state_q <= ST_V1;
					end else begin
						p_q     <= mul_p;
						state_q <= ST_L5;
					end
				end
				ST_L5: begin
					p_q     <= p_q + mul_p;
					ret_q   <= ST_L6;
					state_q <= ST_DSTART;
				end
				ST_L6: begin
					if (quot < 0)
						t_q <= '0;
					else if (quot > $signed({19'd0, len_q}))
						t_q <= len_q;
					else
						t_q <= LEN_W'(quot);
					state_q <= ST_L7;
				end
				ST_L7: begin
					p_q     <= mul_p;
					ret_q   <= ST_L8;
					state_q <= ST_DSTART;
				end
				ST_L8: begin
					sx_q    <= sig_t'(wide_t'(sx_q) - wide_t'(quot));
					p_q     <= mul_p;
					ret_q   <= ST_L9;
					state_q <= ST_DSTART;
				end
				ST_L9: begin
					vx_q    <= sx_q;
					vy_q    <= sig_t'(wide_t'(sy_q) - wide_t'(quot));
					ret_q   <= ST_LDONE;
					state_q <= ST_V1;
				end
				ST_LDONE: begin
					e_q     <= wide_t'(sr_q) - wide_t'(LINE_HALF_W);
					has_q   <= 1'b1;
					state_q <= ST_MERGE;
				end
				ST_MERGE: begin
					if (!(it_q.last && out_valid_q)) begin
						running_min_q <= DIST_W'(merge_sat);
						if (it_q.last) begin
							dist_q      <= DIST_W'(merge_sat);
							out_valid_q <= 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== hw/rtl/sdf_shape_distance_merge.sv =====
// top level of the shape distance merge block
// Each input beat carries one pixel position and one shape (line, rounded box,
// triangle, circle or none). A beat flagged first seeds the pixel with the
// negated distance to the frame box [0,extent_w] x [0,extent_h]; every shape
// then folds its signed distance into a running minimum, and a beat flagged
// last delivers that minimum, saturated to 18 bits, as one output beat. The
// front end passes each accepted beat into a two-entry queue; the back end
// works one item at a time on a shared 22x22 multiplier, a one-bit-per-cycle
// square root and a one-bit-per-cycle divider. Results wait in an output
// register; while it is full a further last beat holds in the back end and
// the queue keeps filling.
// Frame extents are written through cfg_we/cfg_index/cfg_data and reset to 1.0.
module sdf_shape_distance_merge
	import sdfm_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic                     cfg_index,
	input  logic [POS_W-1:0]         cfg_data,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [POS_W-1:0]         pixel_x,
	input  logic [POS_W-1:0]         pixel_y,
	input  logic [KIND_W-1:0]        shape_kind,
	input  logic [POS_W-1:0]         center_x,
	input  logic [POS_W-1:0]         center_y,
	input  logic [SIZE_W-1:0]        shape_size,
	input  logic signed [ROT_W-1:0]  rot_cos,
	input  logic signed [ROT_W-1:0]  rot_sin,
	input  logic                     first_shape,
	input  logic                     last_shape,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [DIST_W-1:0] distance
);

	// front to queue
	logic  q_push, q_full;
	item_t q_in;
	// queue to back end
	logic  q_pop, q_nempty;
	item_t q_out;

	// classification and frame offsets, one beat per cycle while the queue is not full
	sdfm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.pixel_x    (pixel_x),
		.pixel_y    (pixel_y),
		.shape_kind (shape_kind),
		.center_x   (center_x),
		.center_y   (center_y),
		.shape_size (shape_size),
		.rot_cos    (rot_cos),
		.rot_sin    (rot_sin),
		.first_shape(first_shape),
		.last_shape (last_shape),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_item     (q_in)
	);

	// decouples the two halves so each may stall on its own
	sdfm_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_item(q_in),
		.full     (q_full),
		.pop      (q_pop),
		.pop_item (q_out),
		.nempty   (q_nempty)
	);

	// distance evaluation, merge and output register
	sdfm_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_nempty (q_nempty),
		.q_item   (q_out),
		.q_pop    (q_pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.distance (distance)
	);

endmodule

// ===== hw/rtl/sdfm_checker.sv =====
// port level checker of the shape distance merge block and its bind
`include "assert_macros.svh"
module sdfm_checker
	import sdfm_pkg::*;
(
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_valid,
	input logic                     in_stall,
	input logic                     out_valid,
	input logic                     out_stall,
	input logic signed [DIST_W-1:0] distance
);

	// a stalled result beat stays put
	`SDFM_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(distance), "result beat changed while stalled")

	// the output register empties before it takes a new result
	`SDFM_ASSERT(a_out_gap, out_valid && !out_stall |=> !out_valid, "result beat reloaded without a gap")

	// the queue only fills by taking a beat
	`SDFM_ASSERT(a_stall_cause, $rose(in_stall) |-> $past(in_valid && !in_stall), "stall rose without an accepted beat")

	// reset empties queue and output register
	`SDFM_ASSERT_RST(a_reset_clear, !arst_n |-> !out_valid && !in_stall, "state not cleared in reset")

endmodule

bind sdf_shape_distance_merge sdfm_checker u_sdfm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_stall (in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.distance (distance)
);

// ===== sim/testbench.sv =====
// self-checking testbench of the shape distance merge block
module testbench;
	import sdfm_pkg::*;

	typedef struct {
		logic [POS_W-1:0]        px;
		logic [POS_W-1:0]        py;
		logic [KIND_W-1:0]       kind;
		logic [POS_W-1:0]        cx;
		logic [POS_W-1:0]        cy;
		logic [SIZE_W-1:0]       sz;
		logic signed [ROT_W-1:0] cs;
		logic signed [ROT_W-1:0] sn;
		logic                    first;
		logic                    last;
	} shape_beat_t;

	localparam int DRAIN_CYCLES = 1000;
	localparam longint DIST_MAX = 131071;
	localparam longint DIST_MIN = -131072;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_index;
	logic [POS_W-1:0] cfg_data;
	logic in_valid;
	logic in_stall;
	logic [POS_W-1:0] pixel_x, pixel_y, center_x, center_y;
	logic [KIND_W-1:0] shape_kind;
	logic [SIZE_W-1:0] shape_size;
	logic signed [ROT_W-1:0] rot_cos, rot_sin;
	logic first_shape, last_shape;
	logic out_valid;
	logic out_stall;
	logic signed [DIST_W-1:0] distance;

	shape_beat_t beats_to_send[$];
	logic signed [DIST_W-1:0] dist_due[$];

	// predictor state, kept in step with the block
	longint merged_min;
	longint frame_w, frame_h;

	int mismatches;
	int beats_taken;
	int results_taken;
	bit in_beat_taken;
	bit long_hold_done;
	int send_gap;
	int recv_hold;

	sdf_shape_distance_merge uut (.*);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic longint round_shift(longint v, int s);
		return (v + (longint'(1) << (s - 1))) >>> s;
	endfunction

	function automatic longint floor_sqrt(longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = longint'(1) << 62;
		while (b > n)
			b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return longint'(r);
	endfunction

	function automatic longint vec_len(longint x, longint y);
		return floor_sqrt(longint'(x * x) + longint'(y * y));
	endfunction

	function automatic longint abs_l(longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic longint max_l(longint a, longint b);
		return a > b ? a : b;
	endfunction

	function automatic longint min_l(longint a, longint b);
		return a < b ? a : b;
	endfunction

	function automatic longint rbox_dist(longint x, longint y, longint hx, longint hy,
			longint rad);
		longint qx, qy;
		qx = abs_l(x) - (hx - rad);
		qy = abs_l(y) - (hy - rad);
		return min_l(max_l(qx, qy), 0) + vec_len(max_l(qx, 0), max_l(qy, 0)) - rad;
	endfunction

	// folds one shape into the running minimum, returns 1 when a result is due
	function automatic bit merge_shape(shape_beat_t b, output logic signed [DIST_W-1:0] res);
		longint px, py, cx, cy, sz, cs, sn, acc, e, dx, dy, rx, ry;
		longint hw, hh, hvx, hvy, sx, sy, dirx, diry, len, t, qx, qy, a;
		bit has;
		px = b.px; py = b.py; cx = b.cx; cy = b.cy; sz = b.sz;
		cs = b.cs; sn = b.sn;
		has = 1'b1;
		e = 0;
		if (b.first) begin
			hw = frame_w >> 1;
			hh = frame_h >> 1;
			acc = -rbox_dist(px - hw, py - hh, hw, hh, 0);
		end else begin
			acc = merged_min;
		end
		dx = px - cx;
		dy = py - cy;
		rx = round_shift(dx * cs - dy * sn, ROT_BITS);
		ry = round_shift(dx * sn + dy * cs, ROT_BITS);
		case (b.kind)
			KIND_LINE: begin
				hvx = round_shift(sz * cs, ROT_BITS + 1);
				hvy = round_shift(sz * sn, ROT_BITS + 1);
				sx = cx - hvx - px;
				sy = cy - hvy - py;
				dirx = -2 * hvx;
				diry = -2 * hvy;
				len = vec_len(dirx, diry);
				qx = sx;
				qy = sy;
				// segment collapsed to a point: plain point distance
				if (len != 0) begin
					t = (sx * dirx + sy * diry) / len;
					t = max_l(0, min_l(len, t));
					qx = sx - (t * dirx) / len;
					qy = sy - (t * diry) / len;
				end
				e = vec_len(qx, qy) - LINE_HALF_W;
			end
			KIND_BOX: e = rbox_dist(rx, ry, sz >> 1, sz >> 1, CORNER_RAD);
			KIND_TRI: begin
				a = round_shift(abs_l(rx) * K_SQRT3_2 + ry * (ONE >> 1), FRAC_BITS);
				e = max_l(a, -ry) - (sz >> 1);
			end
			KIND_CIRCLE: e = vec_len(dx, dy) - sz;
			default: has = 1'b0;
		endcase
		if (has)
			acc = min_l(acc, e);
		if (acc > DIST_MAX)
			acc = DIST_MAX;
		if (acc < DIST_MIN)
			acc = DIST_MIN;
		merged_min = acc;
		res = DIST_W'(acc);
		return b.last;
	endfunction

	// input side: watch accepted beats and feed the predictor
	always @(posedge clk) begin
		logic signed [DIST_W-1:0] r;
		shape_beat_t b;
		if (arst_n && in_valid && !in_stall) begin
			b.px = pixel_x; b.py = pixel_y; b.kind = shape_kind;
			b.cx = center_x; b.cy = center_y; b.sz = shape_size;
			b.cs = rot_cos; b.sn = rot_sin;
			b.first = first_shape; b.last = last_shape;
			if (merge_shape(b, r))
				dist_due.push_back(r);
			beats_taken++;
			in_beat_taken = 1'b1;
		end
	end

	// output side: compare each result beat with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			results_taken++;
			if (dist_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat: distance %0d", distance);
			end else begin
				if (distance !== dist_due[0]) begin
					mismatches++;
					if (mismatches <= 10)
						$display("distance mismatch: expected %0d, got %0d",
							dist_due[0], distance);
				end
				void'(dist_due.pop_front());
			end
		end
	end

	// sender: one beat per handshake, random gap drawn per beat
	always @(negedge clk) begin
		shape_beat_t b;
		if (arst_n) begin
			if (!in_valid || in_beat_taken) begin
				in_beat_taken = 1'b0;
				if (send_gap > 0) begin
					in_valid <= 1'b0;
					send_gap--;
				end else if (beats_to_send.size() != 0) begin
					b = beats_to_send.pop_front();
					pixel_x <= b.px; pixel_y <= b.py; shape_kind <= b.kind;
					center_x <= b.cx; center_y <= b.cy; shape_size <= b.sz;
					rot_cos <= b.cs; rot_sin <= b.sn;
					first_shape <= b.first; last_shape <= b.last;
					in_valid <= 1'b1;
					// gaps come in runs, with long stretches of back-to-back beats
					send_gap = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 17) : 0;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: random stall per result, plus one long hold-off to fill the block
	always @(negedge clk) begin
		if (arst_n) begin
			if (!long_hold_done && beats_taken >= 300) begin
				long_hold_done = 1'b1;
				recv_hold = 3000;
			end
			if (recv_hold > 0) begin
				out_stall <= 1'b1;
				recv_hold--;
			end else begin
				out_stall <= 1'b0;
				if (out_valid)
					recv_hold = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 17) : 0;
			end
		end
	end

	task automatic settle();
		wait (beats_to_send.size() == 0 && !in_valid && dist_due.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_extents(logic [POS_W-1:0] w, logic [POS_W-1:0] h);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_EXTENT_W;
		cfg_data <= w;
		@(negedge clk);
		cfg_index <= REG_EXTENT_H;
		cfg_data <= h;
		@(negedge clk);
		cfg_we <= 1'b0;
		frame_w = w;
		frame_h = h;
	endtask

	task automatic add_beat(logic [POS_W-1:0] px, logic [POS_W-1:0] py,
			logic [KIND_W-1:0] kind, logic [POS_W-1:0] cx, logic [POS_W-1:0] cy,
			logic [SIZE_W-1:0] sz, int cs, int sn, bit first, bit last);
		shape_beat_t b;
		b.px = px; b.py = py; b.kind = kind; b.cx = cx; b.cy = cy; b.sz = sz;
		b.cs = ROT_W'(cs); b.sn = ROT_W'(sn); b.first = first; b.last = last;
		beats_to_send.push_back(b);
	endtask

	function automatic logic [POS_W-1:0] rand_pos();
		// mostly inside a frame of a few units, now and then anywhere
		return ($urandom_range(0, 4) == 0) ? POS_W'($urandom) : POS_W'($urandom_range(0, 40000));
	endfunction

	task automatic rand_pixels(int n);
		int shapes, k, ang;
		logic [POS_W-1:0] px, py;
		bit noise;
		while (n > 0) begin
			noise = ($urandom_range(0, 6) == 0);
			shapes = $urandom_range(1, 4);
			px = rand_pos();
			py = rand_pos();
			for (k = 0; k < shapes; k++) begin
				ang = $urandom_range(0, 3);
				add_beat(px, py,
					($urandom_range(0, 9) == 0) ? KIND_W'($urandom_range(4, 7))
						: KIND_W'($urandom_range(0, 3)),
					rand_pos(), rand_pos(), SIZE_W'($urandom),
					(ang == 0) ? 16384 : $urandom_range(0, 32768) - 16384,
					(ang == 0) ? 0 : $urandom_range(0, 32768) - 16384,
					noise ? $urandom_range(0, 1) : (k == 0),
					noise ? $urandom_range(0, 1) : (k == shapes - 1));
				n--;
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_EXTENT_W;
		cfg_data = '0;
		in_valid = 1'b0;
		out_stall = 1'b0;
		pixel_x = '0; pixel_y = '0; shape_kind = KIND_NONE;
		center_x = '0; center_y = '0; shape_size = '0;
		rot_cos = '0; rot_sin = '0; first_shape = 1'b0; last_shape = 1'b0;
		merged_min = 0;
		frame_w = ONE;
		frame_h = ONE;
		mismatches = 0;
		beats_taken = 0;
		results_taken = 0;
		in_beat_taken = 1'b0;
		long_hold_done = 1'b0;
		send_gap = 0;
		recv_hold = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: no first flag straight out of reset merges into zero
		add_beat(8192, 8192, KIND_CIRCLE, 8192, 8192, 100, 16384, 0, 0, 1);
		// after an emitted result the minimum carries over
		add_beat(0, 0, KIND_NONE, 0, 0, 0, 16384, 0, 0, 1);
		add_beat(16384, 16384, KIND_LINE, 0, 0, 16383, -16384, 0, 1, 1);
		add_beat(0, 16384, KIND_LINE, 131071, 131071, 0, 16384, 16384, 1, 1);
		add_beat(4000, 9000, KIND_LINE, 8192, 8192, 12000, 11585, 11585, 1, 1);
		add_beat(131071, 131071, KIND_BOX, 0, 0, 16383, 0, -16384, 1, 1);
		add_beat(9000, 7000, KIND_BOX, 8192, 8192, 8000, 11585, -11585, 1, 1);
		add_beat(8192, 12000, KIND_TRI, 8192, 8192, 9000, 16384, 0, 1, 1);
		add_beat(0, 131071, KIND_TRI, 131071, 0, 0, -16384, -16384, 1, 1);
		add_beat(8192, 8192, KIND_CIRCLE, 8192, 8192, 16383, 16384, 16384, 1, 1);
		add_beat(8192, 8192, KIND_NONE, 0, 0, 0, 0, 0, 1, 1);
		// unused kinds leave the minimum untouched
		add_beat(5000, 5000, 3'd5, 0, 0, 0, 0, 0, 1, 0);
		add_beat(5000, 5000, 3'd6, 0, 0, 0, 0, 0, 0, 0);
		add_beat(5000, 5000, 3'd7, 0, 0, 0, 0, 0, 0, 1);
		// one pixel, every kind in turn
		add_beat(6000, 10000, KIND_LINE, 9000, 9000, 5000, 0, 16384, 1, 0);
		add_beat(6000, 10000, KIND_BOX, 2000, 3000, 4000, 16384, 0, 0, 0);
		add_beat(6000, 10000, KIND_TRI, 12000, 1000, 7000, 0, -16384, 0, 0);
		add_beat(6000, 10000, KIND_CIRCLE, 6100, 9900, 3000, 16384, 0, 0, 1);
		settle();

		// extremes of the frame, far pixels drive the result into saturation
		write_extents('0, '0);
		add_beat(131071, 131071, KIND_NONE, 0, 0, 0, 0, 0, 1, 1);
		add_beat(0, 0, KIND_CIRCLE, 0, 0, 16383, 16384, 0, 1, 1);
		rand_pixels(150);
		settle();
		write_extents('1, '1);
		add_beat(65535, 65535, KIND_NONE, 0, 0, 0, 0, 0, 1, 1);
		rand_pixels(350);
		settle();
		write_extents(POS_W'($urandom_range(0, 65535)), POS_W'($urandom_range(0, 65535)));
		rand_pixels(400);
		settle();
		write_extents(POS_W'($urandom), POS_W'($urandom));
		rand_pixels(350);
		settle();

		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#50000000;
		$display("Some tests failed");
		$finish;
	end

endmodule
